// File: rtl/ptfi_pkg.sv
// shared constants and types for the pulse train fault injector
package ptfi_pkg;

   localparam int DEF_COUNTER_WIDTH = 64;
   localparam int DEF_MODULUS_WIDTH = 16;

   localparam int SKIP_LENGTH_RESET = 2;
   localparam int PHASE_WIDTH       = 3;
   localparam int INSERT_HIGH_PHASE = 2;
   localparam int INSERT_LAST_PHASE = 4;

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SKIP_MODULUS  = 2'd0,
      CSR_SKIP_LENGTH   = 2'd1,
      CSR_EXTRA_MODULUS = 2'd2
   } csr_index_type;

   // packed so that pulse_level lands in bit 0
   typedef struct packed {
      logic skipping;
      logic driven;
      logic pulse_level;
   } pulse_result_type;

   // one step of the core: whether a transfer happens and its tick bit
   typedef struct packed {
      logic step;
      logic tick;
   } step_ctrl_type;

endpackage

// File: rtl/pulse_train_fault_injector.sv
// top level of the pulse train fault injector: stream handshake and result register
//
// usage: each transfer on the req_ channel carries one tick bit (tdata bit 0).
// every transfer, tick high or low, yields exactly one transfer on the rsp_
// channel with pulse_level, driven and skipping in tdata bits 0, 1 and 2.
// a tick low leaves all state alone and reports the held level with driven 0.
// the result is registered: a request taken at one edge shows as rsp_tvalid in the next cycle.
// throughput is one tick per cycle while the receiver takes results; the tick counter increment and the two
// remainder add-and-compare paths sit between the state and the result register.
// when the receiver stalls, the result register holds its transfer and
// req_tready drops until it is taken; a request is still accepted in the same
// cycle that the pending result leaves.
// the csr_ channel writes skip_modulus (0), skip_length (1) and extra_modulus (2);
// it is always ready; the user must write it only while the block is idle, as the block does not enforce this.
// reset (synchronous, active high) clears the counters, the line level and the
// result valid flag, and loads skip_length with 2 and both moduli with 0.
module pulse_train_fault_injector
   import ptfi_pkg::*;
#(
   parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH,
   parameter int MODULUS_WIDTH = DEF_MODULUS_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,   // [0] tick
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [0] pulse_level, [1] driven, [2] skipping
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [MODULUS_WIDTH-1:0]   csr_wdata
);

   logic             rsp_valid_ff, rsp_valid_in;
   pulse_result_type rsp_data_ff;
   pulse_result_type result;
   step_ctrl_type    ctrl;
   logic             req_xfer;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ctrl.step = req_xfer;
   assign ctrl.tick = req_tdata[0];

   ptfi_core #(
      .COUNTER_WIDTH(COUNTER_WIDTH),
      .MODULUS_WIDTH(MODULUS_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .ctrl     (ctrl),
      .result   (result)
   );

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_data_ff);

endmodule

// File: rtl/ptfi_core.sv
// configuration registers, tick state and per-tick result logic
module ptfi_core
   import ptfi_pkg::*;
#(
   parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH,
   parameter int MODULUS_WIDTH = DEF_MODULUS_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [MODULUS_WIDTH-1:0]   csr_wdata,
   input  step_ctrl_type              ctrl,
   output pulse_result_type           result
);

   localparam int RW = MODULUS_WIDTH + 1;

   logic [MODULUS_WIDTH-1:0] skip_modulus_ff, skip_length_ff, extra_modulus_ff;

   logic [COUNTER_WIDTH-1:0] tick_counter_ff, tick_counter_in;
   logic [MODULUS_WIDTH-1:0] skip_rem_ff, skip_rem_in;
   logic [MODULUS_WIDTH-1:0] extra_rem_ff, extra_rem_in;
   logic [RW-1:0]            run_count_ff, run_count_in;
   logic [PHASE_WIDTH-1:0]   phase_ff, phase_in;
   logic                     level_ff, level_in;
   logic                     driven;

   logic [MODULUS_WIDTH-1:0] skip_rem_inc, extra_rem_inc;
   logic [RW-1:0]            run_start, run_inc;
   logic [PHASE_WIDTH-1:0]   phase_start, phase_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_modulus_ff  <= '0;
         skip_length_ff   <= MODULUS_WIDTH'(SKIP_LENGTH_RESET);
         extra_modulus_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SKIP_MODULUS:  skip_modulus_ff  <= csr_wdata;
            CSR_SKIP_LENGTH:   skip_length_ff   <= csr_wdata;
            CSR_EXTRA_MODULUS: extra_modulus_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      tick_counter_in = tick_counter_ff;
      skip_rem_in     = skip_rem_ff;
      extra_rem_in    = extra_rem_ff;
      run_count_in    = run_count_ff;
      phase_in        = phase_ff;
      level_in        = level_ff;
      driven          = 1'b0;
      skip_rem_inc    = skip_rem_ff + 1'b1;
      extra_rem_inc   = extra_rem_ff + 1'b1;
      run_start       = run_count_ff;
      run_inc         = '0;
      phase_start     = phase_ff;
      phase_inc       = '0;

      if (ctrl.step && ctrl.tick) begin
         tick_counter_in = tick_counter_ff + 1'b1;
         // running remainders wrap at the modulus, or at full width when it is zero
         skip_rem_in  = (skip_modulus_ff != '0 && skip_rem_inc >= skip_modulus_ff)
                        ? '0 : skip_rem_inc;
         extra_rem_in = (extra_modulus_ff != '0 && extra_rem_inc >= extra_modulus_ff)
                        ? '0 : extra_rem_inc;

         if (extra_modulus_ff == '0) begin
            if (skip_modulus_ff != '0 && skip_rem_in == '0 && run_count_ff == '0)
               run_start = RW'(1);
            if (skip_modulus_ff == '0 || run_start == '0) begin
               level_in = tick_counter_in[0];
               driven   = 1'b1;
            end
            if (run_start != '0) begin
               run_inc      = run_start + 1'b1;
               run_count_in = (run_inc >= {1'b0, skip_length_ff}) ? '0 : run_inc;
            end else begin
               run_count_in = run_start;
            end
         end else begin
            if (extra_rem_in == '0)
               phase_start = PHASE_WIDTH'(1);
            if (phase_start == '0) begin
               level_in = tick_counter_in[1];
            end else begin
               level_in  = (phase_start == PHASE_WIDTH'(INSERT_HIGH_PHASE)) ||
                           (phase_start == PHASE_WIDTH'(INSERT_LAST_PHASE));
               phase_inc = phase_start + 1'b1;
               phase_in  = (phase_inc >= PHASE_WIDTH'(INSERT_LAST_PHASE)) ? '0 : phase_inc;
            end
            driven = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_counter_ff <= '0;
         skip_rem_ff     <= '0;
         extra_rem_ff    <= '0;
         run_count_ff    <= '0;
         phase_ff        <= '0;
         level_ff        <= 1'b0;
      end else if (ctrl.step) begin
         tick_counter_ff <= tick_counter_in;
         skip_rem_ff     <= skip_rem_in;
         extra_rem_ff    <= extra_rem_in;
         run_count_ff    <= run_count_in;
         phase_ff        <= phase_in;
         level_ff        <= level_in;
      end
   end

   assign result.pulse_level = level_in;
   assign result.driven      = driven;
   assign result.skipping    = (run_count_in != '0);

endmodule

// File: rtl/ptfi_checker.sv
// port-level checker for the pulse train fault injector, bound to the top level
module ptfi_checker
   import ptfi_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // every accepted request shows a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no result");

   // no new request while a result is stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted over a stalled result");

   // a tick-low transfer never drives the line
   a_idle_not_driven: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tdata[0] |=> !rsp_tdata[1])
      else $error("line driven without a tick");

endmodule

bind pulse_train_fault_injector ptfi_checker u_ptfi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
